// ===== hw/rtl/wgm_pkg.sv =====
// wgm_pkg: shared constants, request kinds and pattern status struct for the
// wildcard glob matcher. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int NPOS        = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = $clog2(PATTERN_MAX);

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_SUBJECT = 2'd1,
    KIND_END     = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  // pattern view handed from the pattern store to the position set
  typedef struct packed {
    logic [PATTERN_MAX-1:0] star_mask;
    logic [PATTERN_MAX-1:0] hit_mask;
    logic [LEN_W-1:0]       len;
    logic                   ovf;
  } pat_info_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wgm_pattern.sv =====
// wgm_pattern: pattern byte store, length and overflow flag, with per-position
// star flags and byte compare. Depends on wgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wgm_pattern import wgm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire kind_t     kind,
  input  wire logic [7:0] char_byte,
  output pat_info_t      info
);

  logic [7:0]             pat_r [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] star_r;
  logic [PATTERN_MAX-1:0] qm_r;
  logic [PATTERN_MAX-1:0] used_r;
  logic [LEN_W-1:0]       len_r;
  logic                   ovf_r;

  logic do_append;
  logic full;

  assign full      = (len_r == LEN_W'(PATTERN_MAX));
  assign do_append = fire && (kind == KIND_APPEND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ovf_r  <= 1'b0;
      used_r <= '0;
    end else if (fire) begin
      unique case (kind)
        KIND_APPEND: begin
          if (full) begin
            ovf_r <= 1'b1;
          end else begin
            len_r <= len_r + LEN_W'(1);
            used_r[len_r[IDX_W-1:0]] <= 1'b1;
          end
        end
        KIND_CLEAR: begin
          len_r  <= '0;
          ovf_r  <= 1'b0;
          used_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // one cell per pattern position: byte, decoded wildcard flags, compare
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_append && !full && (len_r[IDX_W-1:0] == IDX_W'(i))) begin
        pat_r[i]  <= char_byte;
        star_r[i] <= (char_byte == STAR_BYTE);
        qm_r[i]   <= (char_byte == QMARK_BYTE);
      end
    end

    assign info.star_mask[i] = used_r[i] & star_r[i];
    assign info.hit_mask[i]  = used_r[i] & ~star_r[i] & (qm_r[i] | (pat_r[i] == char_byte));
  end

  assign info.len = len_r;
  assign info.ovf = ovf_r;

endmodule

`default_nettype wire

// ===== hw/rtl/wgm_active.sv =====
// wgm_active: active pattern position set with star closure and per-byte
// advance; gives the match bit on end of subject. Depends on wgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wgm_active import wgm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire kind_t     kind,
  input  wire pat_info_t info,
  output logic           matched
);

  logic [NPOS-1:0] act_r;
  logic [NPOS-1:0] act_nxt;
  logic [NPOS-1:0] star_m;
  logic [NPOS-1:0] seeded;
  logic [NPOS-1:0] closed;
  logic [NPOS-1:0] advanced;
  logic [NPOS-1:0] start_set;

  assign start_set = NPOS'(1);
  assign star_m    = {1'b0, info.star_mask};

  // carry chain runs an active bit through a run of stars and one step past it
  assign seeded = (act_r & star_m) + star_m;
  assign closed = act_r | (seeded ^ star_m);

  assign advanced = (closed & star_m) | {closed[NPOS-2:0] & info.hit_mask, 1'b0};

  assign matched = closed[info.len] & ~info.ovf;

  always_comb begin
    act_nxt = act_r;
    if (fire) begin
      unique case (kind)
        KIND_SUBJECT: act_nxt = advanced;
        default:      act_nxt = start_set;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= start_set;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wildcard_glob_matcher_core.sv =====
// Wildcard glob matcher, the streaming glob match core. A pattern (up to
// PATTERN_MAX = 64 bytes, '*' any run, '?' any one byte) is appended one
// request at a time, then subject bytes stream in and an end-of-subject request
// returns matched and pattern_overflow. Every request is taken into an input
// register and handled from there; one request per clock is sustained while the
// input is not stalled, as all 65 position cells update together (star closure is one
// 65-bit add). Results wait in an output register; only an end-of-subject
// request held behind a stalled result stalls the input.
// Depends on wgm_pkg, wgm_pattern, wgm_active.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_glob_matcher_core import wgm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_kind,
  input  wire logic [7:0] in_char_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_matched,
  output logic            out_pattern_overflow
);

  logic       s_valid_r;
  kind_t      s_kind_r;
  logic [7:0] s_byte_r;
  logic       out_valid_r;
  logic       out_matched_r;
  logic       out_ovf_r;

  logic      fire;
  logic      out_free;
  logic      matched;
  pat_info_t info;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s_valid_r && ((s_kind_r != KIND_END) || out_free);
  assign in_stall = s_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s_kind_r <= kind_t'(in_kind);
      s_byte_r <= in_char_byte;
    end
  end

  wgm_pattern u_pattern (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .kind      (s_kind_r),
    .char_byte (s_byte_r),
    .info      (info)
  );

  wgm_active u_active (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .kind    (s_kind_r),
    .info    (info),
    .matched (matched)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && (s_kind_r == KIND_END)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (s_kind_r == KIND_END)) begin
      out_matched_r <= matched;
      out_ovf_r     <= info.ovf;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

endmodule

`default_nettype wire
